@@ design/dnsrw_pkg.sv @@
// ----------------------------------------------------------------------------
// dnsrw_pkg: shared types and constants for the DNS answer address rewriter
// Transfer payload structs, parser phase codes and fixed header sizes.
// ----------------------------------------------------------------------------
package dnsrw_pkg;

	// one packet byte on the source channel
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	// one packet byte on the destination channel
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       out_changed;
	} out_item_t;

	// parser phases
	localparam int unsigned PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_IP     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_UDP    = 4'd1;
	localparam logic [PHASE_W-1:0] PH_DNSHDR = 4'd2;
	localparam logic [PHASE_W-1:0] PH_QNAME  = 4'd3;
	localparam logic [PHASE_W-1:0] PH_QTAIL  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ANAME  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_ATYPE  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_ACLTTL = 4'd7;
	localparam logic [PHASE_W-1:0] PH_ALEN   = 4'd8;
	localparam logic [PHASE_W-1:0] PH_SKIP   = 4'd9;
	localparam logic [PHASE_W-1:0] PH_WRITE  = 4'd10;
	localparam logic [PHASE_W-1:0] PH_DONE   = 4'd11;

	// field byte counter: largest field is a 60-byte IP header
	localparam int unsigned CNT_W = 6;
	localparam logic [CNT_W-1:0] UDP_HDR_BYTES  = 6'd8;
	localparam logic [CNT_W-1:0] DNS_HDR_BYTES  = 6'd12;
	localparam logic [CNT_W-1:0] ANCOUNT_HI_POS = 6'd6;
	localparam logic [CNT_W-1:0] ANCOUNT_LO_POS = 6'd7;
	localparam logic [CNT_W-1:0] QTAIL_BYTES    = 6'd4;
	localparam logic [CNT_W-1:0] ANAME_BYTES    = 6'd2;
	localparam logic [CNT_W-1:0] ATYPE_BYTES    = 6'd2;
	localparam logic [CNT_W-1:0] ACLTTL_BYTES   = 6'd6;
	localparam logic [CNT_W-1:0] ALEN_BYTES     = 6'd2;
	localparam logic [CNT_W-1:0] ADDR_BYTES     = 6'd4;

	localparam logic [15:0] TYPE_A = 16'h0001;

endpackage

@@ design/dnsrw_parser.sv @@
// ----------------------------------------------------------------------------
// dnsrw_parser: byte-wise IPv4/UDP/DNS response parser
// Tracks the header walk and produces the passed or rewritten byte for the
// current transfer; state advances on each accepted byte.
// ----------------------------------------------------------------------------
module dnsrw_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  dnsrw_pkg::in_item_t  item,
	input  logic [31:0]        new_address,
	output dnsrw_pkg::out_item_t result
);
	import dnsrw_pkg::*;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [15:0]        answers_q, answers_d;
	logic [15:0]        rtype_q, rtype_d;
	logic [15:0]        data_left_q, data_left_d;
	logic [CNT_W-1:0]   hdr_len_q, hdr_len_d;
	logic               done_q, done_d;

	logic [CNT_W-1:0]   cnt_inc;
	logic [15:0]        answers_dec;
	logic [15:0]        data_left_dec;
	logic [15:0]        alen_new;
	logic [7:0]         b;
	logic [7:0]         octet;
	logic               changed;

	assign b             = item.in_byte;
	assign cnt_inc       = cnt_q + 1'b1;
	assign answers_dec   = answers_q - 1'b1;
	assign data_left_dec = data_left_q - 1'b1;
	assign alen_new      = (cnt_q == '0) ? {b, data_left_q[7:0]} : {data_left_q[15:8], b};

	// address octet for the current write position, first octet on top
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    octet = new_address[31:24];
			2'd1:    octet = new_address[23:16];
			2'd2:    octet = new_address[15:8];
			default: octet = new_address[7:0];
		endcase
	end

	// next-state logic for one byte
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		answers_d   = answers_q;
		rtype_d     = rtype_q;
		data_left_d = data_left_q;
		hdr_len_d   = hdr_len_q;
		done_d      = done_q;
		changed     = 1'b0;

		case (phase_q)
			PH_IP: begin
				if (cnt_q == '0)
					hdr_len_d = {b[3:0], 2'b00};
				cnt_d = cnt_inc;
				if (cnt_inc >= hdr_len_d) begin
					phase_d = PH_UDP;
					cnt_d   = '0;
				end
			end
			PH_UDP: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= UDP_HDR_BYTES) begin
					phase_d = PH_DNSHDR;
					cnt_d   = '0;
				end
			end
			PH_DNSHDR: begin
				if (cnt_q == ANCOUNT_HI_POS)
					answers_d = {b, 8'h00};
				else if (cnt_q == ANCOUNT_LO_POS)
					answers_d = {answers_q[15:8], b};
				cnt_d = cnt_inc;
				if (cnt_inc >= DNS_HDR_BYTES) begin
					phase_d = PH_QNAME;
					cnt_d   = '0;
				end
			end
			PH_QNAME: begin
				// name ends at its zero-length label
				if (b == 8'h00) begin
					phase_d = PH_QTAIL;
					cnt_d   = '0;
				end
			end
			PH_QTAIL: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= QTAIL_BYTES) begin
					phase_d = (answers_q == '0) ? PH_DONE : PH_ANAME;
					cnt_d   = '0;
				end
			end
			PH_ANAME: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= ANAME_BYTES) begin
					phase_d = PH_ATYPE;
					cnt_d   = '0;
				end
			end
			PH_ATYPE: begin
				if (cnt_q == '0)
					rtype_d = {b, 8'h00};
				else
					rtype_d = {rtype_q[15:8], b};
				cnt_d = cnt_inc;
				if (cnt_inc >= ATYPE_BYTES) begin
					phase_d = PH_ACLTTL;
					cnt_d   = '0;
				end
			end
			PH_ACLTTL: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= ACLTTL_BYTES) begin
					phase_d = PH_ALEN;
					cnt_d   = '0;
				end
			end
			PH_ALEN: begin
				data_left_d = alen_new;
				cnt_d       = cnt_inc;
				if (cnt_inc >= ALEN_BYTES) begin
					cnt_d = '0;
					if (rtype_q == TYPE_A && !done_q) begin
						phase_d = PH_WRITE;
					end else if (alen_new == '0) begin
						// empty record: next answer starts at once
						answers_d = answers_dec;
						phase_d   = (answers_dec == '0) ? PH_DONE : PH_ANAME;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				data_left_d = data_left_dec;
				if (data_left_dec == '0) begin
					answers_d = answers_dec;
					phase_d   = (answers_dec == '0) ? PH_DONE : PH_ANAME;
					cnt_d     = '0;
				end
			end
			PH_WRITE: begin
				changed = 1'b1;
				cnt_d   = cnt_inc;
				if (cnt_inc >= ADDR_BYTES) begin
					done_d  = 1'b1;
					phase_d = PH_DONE;
					cnt_d   = '0;
				end
			end
			default: begin
			end
		endcase

		// end of packet returns the parser to its start
		if (item.in_last) begin
			phase_d     = PH_IP;
			cnt_d       = '0;
			answers_d   = '0;
			rtype_d     = '0;
			data_left_d = '0;
			hdr_len_d   = '0;
			done_d      = 1'b0;
		end
	end

	assign result.out_byte    = changed ? octet : b;
	assign result.out_last    = item.in_last;
	assign result.out_changed = changed;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IP;
			cnt_q       <= '0;
			answers_q   <= '0;
			rtype_q     <= '0;
			data_left_q <= '0;
			hdr_len_q   <= '0;
			done_q      <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			answers_q   <= answers_d;
			rtype_q     <= rtype_d;
			data_left_q <= data_left_d;
			hdr_len_q   <= hdr_len_d;
			done_q      <= done_d;
		end
	end

endmodule

@@ design/dns_answer_address_rewriter_unit.sv @@
// ----------------------------------------------------------------------------
// dns_answer_address_rewriter_unit: rewrites the first DNS A answer address
// Passes a response packet byte by byte, replacing the four data bytes of
// the first A record with the configured IPv4 address.
// ----------------------------------------------------------------------------
// Throughput: 1 byte per cycle while src_stall is low; the parser updates
// in the cycle a byte lands and a two-entry output stage (result register
// plus skid) registers each byte for dst_valid and absorbs stalls.
// Reset: arst_n clears the parser, the output valids and new_address to 0.
module dns_answer_address_rewriter_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  dnsrw_pkg::in_item_t  src_data,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output dnsrw_pkg::out_item_t dst_data
);
	import dnsrw_pkg::*;

	logic        [31:0] new_address_q;
	logic               accept;
	logic               out_free;
	out_item_t          result;
	out_item_t          out_q, skid_q;
	logic               out_valid_q, skid_valid_q;

	// address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			new_address_q <= '0;
		else if (cfg_wr_en)
			new_address_q <= cfg_wr_data;
	end

	assign src_stall = skid_valid_q;
	assign accept    = src_valid && !skid_valid_q;
	assign out_free  = !out_valid_q || !dst_stall;

	dnsrw_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.item        (src_data),
		.new_address (new_address_q),
		.result      (result)
	);

	// output stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output stage payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule

@@ design/dnsrw_checker.sv @@
// ----------------------------------------------------------------------------
// dnsrw_checker: port-level checks for the rewriter
// Watches the transfer handshakes and the output buffering on the ports.
// ----------------------------------------------------------------------------
module dnsrw_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 src_valid,
	input logic                 src_stall,
	input dnsrw_pkg::in_item_t  src_data,
	input logic                 dst_valid,
	input logic                 dst_stall,
	input dnsrw_pkg::out_item_t dst_data
);
	import dnsrw_pkg::*;

	// a stalled result holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
		else $error("stalled destination transfer changed");

	// source back-pressure only while a result is buffered
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid)
		else $error("source stalled with empty output");

	// back-pressure starts only after a stalled destination cycle
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(src_stall) |-> $past(dst_valid && dst_stall))
		else $error("source stall without destination stall");

	// a stalled source transfer holds its byte
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_data))
		else $error("stalled source transfer changed");

endmodule

bind dns_answer_address_rewriter_unit dnsrw_checker u_dnsrw_checker (.*);
